// File: src/bmnp_pkg.sv
// ----------------------------------------------------------------------------
// bmnp_pkg
// Shared types and codes of the bus master node poller.
// ----------------------------------------------------------------------------
package bmnp_pkg;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_DISCOVER = 3'd1;
   localparam logic [2:0] ACT_POLL     = 3'd2;
   localparam logic [2:0] ACT_FLUSH    = 3'd3;
   localparam logic [2:0] ACT_FORWARD  = 3'd4;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_DETECT = 3'd1;
   localparam logic [2:0] PH_FLUSH  = 3'd2;
   localparam logic [2:0] PH_GAP    = 3'd3;
   localparam logic [2:0] PH_POLL   = 3'd4;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_MSG    = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] OP_ANNOUNCE = 2'd0;
   localparam logic [1:0] OP_DONE     = 2'd1;
   localparam logic [1:0] OP_OTHER    = 2'd2;

   localparam logic [7:0] REG_POLL_GAP     = 8'd0;
   localparam logic [7:0] REG_POLL_TIMEOUT = 8'd1;
   localparam logic [7:0] REG_DETECT_INT   = 8'd2;
   localparam logic [7:0] REG_NODE_SPACING = 8'd3;

   localparam logic [7:0] BOOT_GRACE = 8'd200;

   // node record as kept in the record memory
   typedef struct packed {
      logic [7:0]  module_id;
      logic [7:0]  grace;
      logic [31:0] last_contact;
   } node_rec_type;

endpackage

// File: src/bmnp_elapsed.sv
// ----------------------------------------------------------------------------
// bmnp_elapsed
// Shared timer compare: wrapped difference of now and start against a length.
// ----------------------------------------------------------------------------
module bmnp_elapsed (
   input  logic [31:0] now,
   input  logic [31:0] start,
   input  logic [31:0] len,
   output logic        done
);

   logic [31:0] diff;

   assign diff = now - start;
   assign done = (diff >= len);

endmodule

// File: src/bmnp_rec_mem.sv
// ----------------------------------------------------------------------------
// bmnp_rec_mem
// Node record memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmnp_rec_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  bmnp_pkg::node_rec_type wr_data,
   input  logic [AW-1:0]         rd_addr,
   output bmnp_pkg::node_rec_type rd_data
);

   bmnp_pkg::node_rec_type mem [DEPTH];
   bmnp_pkg::node_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bus_master_node_poller_top.sv
// a request beat passes the read, execute, query read and output steps before the response is
// valid; a tick that reaches the poll step adds a detect check step and a scan step per scanned node
// req_tready is high only while the sequencer is idle, so a new request is taken only once the
// previous one has passed its output step; a stalled response holds the sequencer in its output step
// reset is synchronous, active high; it clears phase, timers, node flags and
// restores register defaults; node records read as zero until written
// ----------------------------------------------------------------------------
// bus_master_node_poller_top
// Polling master with discovery for a multi-drop bus, run by a small sequencer.
// ----------------------------------------------------------------------------
module bus_master_node_poller_top #(
   parameter int MAX_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms, queue_pending, msg_node, msg_transport, msg_op, msg_len,
   // msg_data0, msg_data1, query_node
   input  logic [79:0] req_tdata,
   // cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // action, action_node, master_state, active_count, any_found, lost_node,
   // q_active, q_module, q_boot, q_last_contact
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic [7:0] MAXN = 8'(MAX_NODES);
   localparam logic [7:0] SCAN_LAST = 8'(MAX_NODES - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDP    = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_DETCHK = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_QRD    = 3'd5;
   localparam logic [2:0] S_QOUT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [15:0] gap_len_ff, tmo_len_ff, spacing_ff;
   logic [31:0] det_int_ff, win_len_ff;

   logic [1:0]  cmd_ff;
   logic [31:0] now_ff;
   logic        queued_ff, trans_ff;
   logic [7:0]  mnode_ff, mlen_ff, d0_ff, d1_ff, query_ff;
   logic [1:0]  op_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [MAX_NODES-1:0] active_ff, active_in, written_ff, written_in;
   logic [7:0]  count_ff, count_in;
   logic        found_ff, found_in;
   logic [7:0]  pending_ff, pending_in;
   logic [31:0] poll_start_ff, poll_start_in, gap_start_ff, gap_start_in;
   logic [31:0] det_start_ff, det_start_in, win_start_ff, win_start_in;
   logic [2:0]  act_ff, act_in;
   logic [7:0]  act_node_ff, act_node_in, lost_ff, lost_in;
   logic [7:0]  scan_id_ff, scan_id_in, scan_k_ff, scan_k_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;

   logic [31:0] el_start, el_len;
   logic        el_done;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   bmnp_pkg::node_rec_type wr_data, rd_data, rec_cur;

   logic        mnode_ok, pend_ok, q_ok;
   logic [AW-1:0] mnode_ix, pend_ix, q_ix, next_ix;
   logic [7:0]  scan_next;

   assign mnode_ok  = (mnode_ff >= 8'd1) && (mnode_ff <= MAXN);
   assign pend_ok   = (pending_ff >= 8'd1) && (pending_ff <= MAXN);
   assign q_ok      = (query_ff >= 8'd1) && (query_ff <= MAXN);
   assign mnode_ix  = AW'(mnode_ff - 8'd1);
   assign pend_ix   = AW'(pending_ff - 8'd1);
   assign q_ix      = AW'(query_ff - 8'd1);
   assign scan_next = (scan_id_ff >= MAXN) ? 8'd1 : (scan_id_ff + 8'd1);
   assign next_ix   = AW'(scan_next - 8'd1);

   // record of the pending node, zero until it was written
   assign rec_cur = written_ff[pend_ix] ? rd_data : '0;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // timer operands
   always_comb begin
      el_start = det_start_ff;
      el_len   = det_int_ff;
      if (state_ff == S_EXEC) begin
         case (phase_ff)
            bmnp_pkg::PH_DETECT: begin
               el_start = win_start_ff;
               el_len   = win_len_ff;
            end
            bmnp_pkg::PH_GAP: begin
               el_start = gap_start_ff;
               el_len   = {16'd0, gap_len_ff};
            end
            default: begin
               el_start = poll_start_ff;
               el_len   = {16'd0, tmo_len_ff};
            end
         endcase
      end
   end

   bmnp_elapsed u_elapsed (
      .now   (now_ff),
      .start (el_start),
      .len   (el_len),
      .done  (el_done)
   );

   // queried record stays on the read port while the response waits
   assign rd_addr = (state_ff == S_QRD || state_ff == S_QOUT) ? q_ix : pend_ix;

   bmnp_rec_mem #(
      .DEPTH (MAX_NODES),
      .AW    (AW)
   ) u_rec_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      active_in     = active_ff;
      written_in    = written_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      pending_in    = pending_ff;
      poll_start_in = poll_start_ff;
      gap_start_in  = gap_start_ff;
      det_start_in  = det_start_ff;
      win_start_in  = win_start_ff;
      act_in        = act_ff;
      act_node_in   = act_node_ff;
      lost_in       = lost_ff;
      scan_id_in    = scan_id_ff;
      scan_k_in     = scan_k_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_ix;
      wr_data       = rec_cur;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in      = bmnp_pkg::ACT_NONE;
               act_node_in = 8'd0;
               lost_in     = 8'd0;
               state_in    = S_RDP;
            end
         end
         S_RDP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_QRD;
            case (cmd_ff)
               bmnp_pkg::CMD_START: begin
                  phase_in     = bmnp_pkg::PH_DETECT;
                  det_start_in = now_ff;
                  win_start_in = now_ff;
                  act_in       = bmnp_pkg::ACT_DISCOVER;
               end
               bmnp_pkg::CMD_MSG: begin
                  if (!trans_ff) begin
                     act_in = bmnp_pkg::ACT_FORWARD;
                  end else if (op_ff == bmnp_pkg::OP_ANNOUNCE) begin
                     if (mnode_ok) begin
                        if (!active_ff[mnode_ix]) begin
                           count_in = count_ff + 8'd1;
                        end
                        active_in[mnode_ix]  = 1'b1;
                        written_in[mnode_ix] = 1'b1;
                        found_in             = 1'b1;
                        wr_en                = 1'b1;
                        wr_addr              = mnode_ix;
                        wr_data.module_id    = (mlen_ff >= 8'd1) ? d0_ff : 8'd0;
                        wr_data.grace        = (mlen_ff >= 8'd2 && d1_ff != 8'd0) ?
                                               bmnp_pkg::BOOT_GRACE : 8'd0;
                        wr_data.last_contact = now_ff;
                     end
                  end else if (op_ff == bmnp_pkg::OP_DONE) begin
                     if (phase_ff == bmnp_pkg::PH_POLL && mnode_ff == pending_ff &&
                         pend_ok) begin
                        phase_in             = bmnp_pkg::PH_FLUSH;
                        written_in[pend_ix]  = 1'b1;
                        wr_en                = 1'b1;
                        wr_data.last_contact = now_ff;
                     end
                  end
               end
               bmnp_pkg::CMD_TICK: begin
                  case (phase_ff)
                     bmnp_pkg::PH_DETECT: begin
                        if (el_done) begin
                           phase_in = bmnp_pkg::PH_FLUSH;
                        end
                     end
                     bmnp_pkg::PH_FLUSH: begin
                        if (queued_ff) begin
                           act_in       = bmnp_pkg::ACT_FLUSH;
                           phase_in     = bmnp_pkg::PH_GAP;
                           gap_start_in = now_ff;
                        end else begin
                           state_in = S_DETCHK;
                        end
                     end
                     bmnp_pkg::PH_GAP: begin
                        if (el_done) begin
                           state_in = S_DETCHK;
                        end
                     end
                     bmnp_pkg::PH_POLL: begin
                        if (el_done) begin
                           phase_in = bmnp_pkg::PH_FLUSH;
                           if (pend_ok) begin
                              if (rec_cur.grace != 8'd0) begin
                                 written_in[pend_ix] = 1'b1;
                                 wr_en               = 1'b1;
                                 wr_data.grace       = rec_cur.grace - 8'd1;
                              end else begin
                                 active_in[pend_ix] = 1'b0;
                                 lost_in            = pending_ff;
                                 if (active_ff[pend_ix]) begin
                                    count_in = count_ff - 8'd1;
                                    found_in = (count_ff != 8'd1);
                                 end else begin
                                    found_in = (count_ff != 8'd0);
                                 end
                              end
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         S_DETCHK: begin
            if (el_done) begin
               phase_in     = bmnp_pkg::PH_DETECT;
               det_start_in = now_ff;
               win_start_in = now_ff;
               act_in       = bmnp_pkg::ACT_DISCOVER;
               state_in     = S_QRD;
            end else if (!found_ff) begin
               phase_in = bmnp_pkg::PH_FLUSH;
               state_in = S_QRD;
            end else begin
               scan_id_in = pending_ff;
               scan_k_in  = 8'd0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // one candidate node per cycle, round-robin from the last polled
            if (active_ff[next_ix]) begin
               phase_in      = bmnp_pkg::PH_POLL;
               pending_in    = scan_next;
               poll_start_in = now_ff;
               act_in        = bmnp_pkg::ACT_POLL;
               act_node_in   = scan_next;
               state_in      = S_QRD;
            end else if (scan_k_ff == SCAN_LAST) begin
               phase_in = bmnp_pkg::PH_FLUSH;
               state_in = S_QRD;
            end else begin
               scan_id_in = scan_next;
               scan_k_in  = scan_k_ff + 8'd1;
            end
         end
         S_QRD: begin
            state_in = S_QOUT;
         end
         S_QOUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[2:0]   = act_ff;
               rsp_data_in[10:3]  = act_node_ff;
               rsp_data_in[13:11] = phase_ff;
               rsp_data_in[21:14] = count_ff;
               rsp_data_in[22]    = found_ff;
               rsp_data_in[30:23] = lost_ff;
               if (q_ok) begin
                  rsp_data_in[31] = active_ff[q_ix];
                  if (written_ff[q_ix]) begin
                     rsp_data_in[39:32] = rd_data.module_id;
                     rsp_data_in[40]    = (rd_data.grace != 8'd0);
                     rsp_data_in[72:41] = rd_data.last_contact;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= bmnp_pkg::PH_START;
         active_ff     <= '0;
         written_ff    <= '0;
         count_ff      <= 8'd0;
         found_ff      <= 1'b0;
         pending_ff    <= 8'd0;
         poll_start_ff <= 32'd0;
         gap_start_ff  <= 32'd0;
         det_start_ff  <= 32'd0;
         win_start_ff  <= 32'd0;
         rsp_valid_ff  <= 1'b0;
         gap_len_ff    <= 16'd10;
         tmo_len_ff    <= 16'd50;
         det_int_ff    <= 32'd60000;
         spacing_ff    <= 16'd10;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         active_ff     <= active_in;
         written_ff    <= written_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         pending_ff    <= pending_in;
         poll_start_ff <= poll_start_in;
         gap_start_ff  <= gap_start_in;
         det_start_ff  <= det_start_in;
         win_start_ff  <= win_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               bmnp_pkg::REG_POLL_GAP:     gap_len_ff <= csr_data[15:0];
               bmnp_pkg::REG_POLL_TIMEOUT: tmo_len_ff <= csr_data[15:0];
               bmnp_pkg::REG_DETECT_INT:   det_int_ff <= csr_data;
               bmnp_pkg::REG_NODE_SPACING: spacing_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      win_len_ff  <= 32'(spacing_ff * (MAX_NODES + 1));
      act_ff      <= act_in;
      act_node_ff <= act_node_in;
      lost_ff     <= lost_in;
      scan_id_ff  <= scan_id_in;
      scan_k_ff   <= scan_k_in;
      rsp_data_ff <= rsp_data_in;
      if (req_tvalid && req_tready) begin
         cmd_ff    <= req_tuser;
         now_ff    <= req_tdata[31:0];
         queued_ff <= req_tdata[32];
         mnode_ff  <= req_tdata[40:33];
         trans_ff  <= req_tdata[41];
         op_ff     <= req_tdata[43:42];
         mlen_ff   <= req_tdata[51:44];
         d0_ff     <= req_tdata[59:52];
         d1_ff     <= req_tdata[67:60];
         query_ff  <= req_tdata[75:68];
      end
   end

`ifndef SYNTHESIS
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == 8'($countones(active_ff)))
      else $error("active count out of step with node flags");

   a_found_implies_none: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> (active_ff == '0))
      else $error("found flag clear while nodes are active");

   a_poll_pending_ok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bmnp_pkg::PH_POLL) |-> pend_ok)
      else $error("polling without a valid pending node");

   a_rsp_from_qout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_QOUT) && (state_ff == S_IDLE))
      else $error("response raised outside the output step");
`endif

endmodule
